>>> sv/brc_pkg.sv
`timescale 1ns / 1ps

package brc_pkg;

    localparam int ID_W_DEF   = 32;
    localparam int FIELD_W    = 32;
    localparam int CNT_W      = 32;
    localparam int REG_W      = 32;
    // prev block + gap + 1 never wraps at this width
    localparam int SUM_W      = REG_W + 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int APB_AW     = 3;

    localparam logic REG_GAP_LIMIT = 1'b0;

    localparam logic ST_RANGE = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    typedef enum logic [1:0] {
        K_FIRST,
        K_JOIN,
        K_SPLIT,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             last;
        logic [CNT_W-1:0] idx;
    } t_cls;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] range_chunk;
        logic [FIELD_W-1:0] range_first;
        logic [FIELD_W-1:0] range_last;
        logic [CNT_W-1:0]   range_item_start;
        logic               final_result;
    } t_res;

endpackage

>>> sv/brc_in_if.sv
`timescale 1ns / 1ps

interface brc_in_if;
    import brc_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] chunk_id;
    logic [FIELD_W-1:0] block_id;
    logic               last_item;

    modport source (output valid, output chunk_id, output block_id, output last_item,
                    input ready);
    modport sink   (input valid, input chunk_id, input block_id, input last_item,
                    output ready);
endinterface

>>> sv/brc_out_if.sv
`timescale 1ns / 1ps

interface brc_out_if;
    import brc_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [FIELD_W-1:0] range_chunk;
    logic [FIELD_W-1:0] range_first;
    logic [FIELD_W-1:0] range_last;
    logic [CNT_W-1:0]   range_item_start;
    logic               final_result;

    modport source (output valid, output status, output range_chunk, output range_first,
                    output range_last, output range_item_start, output final_result,
                    input ready);
    modport sink   (input valid, input status, input range_chunk, input range_first,
                    input range_last, input range_item_start, input final_result,
                    output ready);
endinterface

>>> sv/block_range_coalescer_top.sv
`timescale 1ns / 1ps

// Block range coalescer. Items arrive on i_item (chunk_id, block_id,
// last_item), sorted by chunk then block; merged ranges and ordering errors
// leave on o_res. Both channels move an item when valid and ready are high.
// The user writes gap_limit over the APB port at byte address 0 only while
// idle; the block itself does not enforce this. The front stage classifies
// each item against the previous one (one add of prev block + gap + 1 and
// compares), pushes it into a four-entry queue, and the back stage updates
// the open range and loads the output register. One item per cycle is taken
// while the queue has room. A split on the last item of a list yields two
// results; the second waits in a pending register and holds the back stage.
// When o_res.ready is low the output register holds, the queue fills and
// i_item.ready drops once it holds four items.
// Reset (synchronous, active low) empties the queue and output, closes any
// open range, clears the item index and sets gap_limit to zero.
module block_range_coalescer_top #(
    parameter int ID_WIDTH = brc_pkg::ID_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    brc_in_if.sink                     i_item,
    brc_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brc_pkg::APB_AW-1:0] paddr,
    input  logic [brc_pkg::REG_W-1:0]  pwdata,
    output logic [brc_pkg::REG_W-1:0]  prdata,
    output logic                       pready
);
    import brc_pkg::*;

    logic [REG_W-1:0]    r_gap_limit;
    logic                reg_hit;
    logic                wr_en;

    logic                push;
    logic                push_ready;
    t_cls                push_cls;
    logic [ID_WIDTH-1:0] push_chunk;
    logic [ID_WIDTH-1:0] push_blk;

    logic                q_valid;
    logic                q_pop;
    t_cls                q_cls;
    logic [ID_WIDTH-1:0] q_chunk;
    logic [ID_WIDTH-1:0] q_blk;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_GAP_LIMIT);
    assign wr_en   = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? r_gap_limit : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= '0;
        end else if (wr_en) begin
            r_gap_limit <= pwdata;
        end
    end

    brc_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_gap_limit  (r_gap_limit),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_cls        (push_cls),
        .o_chunk      (push_chunk),
        .o_blk        (push_blk)
    );

    brc_queue #(
        .ID_WIDTH (ID_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (push_cls),
        .i_chunk (push_chunk),
        .i_blk   (push_blk),
        .o_ready (push_ready),
        .o_valid (q_valid),
        .o_cls   (q_cls),
        .o_chunk (q_chunk),
        .o_blk   (q_blk),
        .i_pop   (q_pop)
    );

    brc_back #(
        .ID_WIDTH (ID_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cls     (q_cls),
        .i_chunk   (q_chunk),
        .i_blk     (q_blk),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule

>>> sv/brc_front.sv
`timescale 1ns / 1ps

module brc_front #(
    parameter int ID_WIDTH = brc_pkg::ID_W_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    brc_in_if.sink                    i_item,
    input  logic [brc_pkg::REG_W-1:0] i_gap_limit,
    input  logic                      i_push_ready,
    output logic                      o_push,
    output brc_pkg::t_cls             o_cls,
    output logic [ID_WIDTH-1:0]       o_chunk,
    output logic [ID_WIDTH-1:0]       o_blk
);
    import brc_pkg::*;

    logic                r_open;
    logic                r_err;
    logic [CNT_W-1:0]    r_items;
    logic [ID_WIDTH-1:0] r_prev_chunk;
    logic [ID_WIDTH-1:0] r_prev_blk;

    logic                n_open;
    logic                n_err;
    logic [CNT_W-1:0]    n_items;

    logic                accept;
    logic [ID_WIDTH-1:0] ch;
    logic [ID_WIDTH-1:0] blk;
    logic                eq_chunk;
    logic                bad_order;
    logic [SUM_W-1:0]    reach;
    logic                can_join;
    t_kind               kind;

    assign i_item.ready = i_push_ready;
    assign accept       = i_item.valid && i_push_ready;

    assign ch  = i_item.chunk_id[ID_WIDTH-1:0];
    assign blk = i_item.block_id[ID_WIDTH-1:0];

    // open range always ends at the previous item of the list
    assign eq_chunk  = (ch == r_prev_chunk);
    assign bad_order = (ch < r_prev_chunk) || (eq_chunk && (blk <= r_prev_blk));
    assign reach     = SUM_W'(r_prev_blk) + SUM_W'(i_gap_limit) + SUM_W'(1);
    assign can_join  = eq_chunk && (SUM_W'(blk) <= reach);

    always_comb begin
        if (!r_open) begin
            kind = K_FIRST;
        end else if (bad_order) begin
            kind = K_ERROR;
        end else if (can_join) begin
            kind = K_JOIN;
        end else begin
            kind = K_SPLIT;
        end
    end

    assign o_push        = accept && !r_err;
    assign o_cls.kind    = kind;
    assign o_cls.last    = i_item.last_item;
    assign o_cls.idx     = r_items;
    assign o_chunk       = ch;
    assign o_blk         = blk;

    always_comb begin
        n_open  = r_open;
        n_err   = r_err;
        n_items = r_items;
        if (accept) begin
            if (r_items != {CNT_W{1'b1}}) begin
                n_items = r_items + CNT_W'(1);
            end
            if (r_err) begin
                if (i_item.last_item) begin
                    n_err   = 1'b0;
                    n_items = '0;
                end
            end else if (kind == K_ERROR) begin
                n_open = 1'b0;
                if (i_item.last_item) begin
                    n_items = '0;
                end else begin
                    n_err = 1'b1;
                end
            end else if (i_item.last_item) begin
                n_open  = 1'b0;
                n_items = '0;
            end else begin
                n_open = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_err   <= 1'b0;
            r_items <= '0;
        end else begin
            r_open  <= n_open;
            r_err   <= n_err;
            r_items <= n_items;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev_chunk <= ch;
            r_prev_blk   <= blk;
        end
    end

endmodule

>>> sv/brc_queue.sv
`timescale 1ns / 1ps

module brc_queue #(
    parameter int ID_WIDTH = brc_pkg::ID_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  brc_pkg::t_cls       i_cls,
    input  logic [ID_WIDTH-1:0] i_chunk,
    input  logic [ID_WIDTH-1:0] i_blk,
    output logic                o_ready,
    output logic                o_valid,
    output brc_pkg::t_cls       o_cls,
    output logic [ID_WIDTH-1:0] o_chunk,
    output logic [ID_WIDTH-1:0] o_blk,
    input  logic                i_pop
);
    import brc_pkg::*;

    t_cls                r_cls   [Q_DEPTH];
    logic [ID_WIDTH-1:0] r_chunk [Q_DEPTH];
    logic [ID_WIDTH-1:0] r_blk   [Q_DEPTH];

    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W:0]    r_count;

    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_count != (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    assign o_cls   = r_cls[r_rd_ptr];
    assign o_chunk = r_chunk[r_rd_ptr];
    assign o_blk   = r_blk[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (Q_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (Q_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_cls[r_wr_ptr]   <= i_cls;
            r_chunk[r_wr_ptr] <= i_chunk;
            r_blk[r_wr_ptr]   <= i_blk;
        end
    end

endmodule

>>> sv/brc_back.sv
`timescale 1ns / 1ps

module brc_back #(
    parameter int ID_WIDTH = brc_pkg::ID_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  brc_pkg::t_cls       i_cls,
    input  logic [ID_WIDTH-1:0] i_chunk,
    input  logic [ID_WIDTH-1:0] i_blk,
    output logic                o_pop,
    brc_out_if.source           o_res
);
    import brc_pkg::*;

    logic                r_out_valid;
    t_res                r_out;
    logic                r_pend_valid;
    t_res                r_pend;
    logic [ID_WIDTH-1:0] r_open_chunk;
    logic [ID_WIDTH-1:0] r_open_first;
    logic [ID_WIDTH-1:0] r_open_last;
    logic [CNT_W-1:0]    r_open_start;

    logic                n_out_valid;
    t_res                n_out;
    logic                n_pend_valid;
    t_res                n_pend;
    logic [ID_WIDTH-1:0] n_open_chunk;
    logic [ID_WIDTH-1:0] n_open_first;
    logic [ID_WIDTH-1:0] n_open_last;
    logic [CNT_W-1:0]    n_open_start;

    logic                out_free;
    t_res                res_old;
    t_res                res_new;
    t_res                res_join;
    t_res                res_err;

    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        res_old.status           = ST_RANGE;
        res_old.range_chunk      = FIELD_W'(r_open_chunk);
        res_old.range_first      = FIELD_W'(r_open_first);
        res_old.range_last       = FIELD_W'(r_open_last);
        res_old.range_item_start = r_open_start;
        res_old.final_result     = 1'b0;

        res_new.status           = ST_RANGE;
        res_new.range_chunk      = FIELD_W'(i_chunk);
        res_new.range_first      = FIELD_W'(i_blk);
        res_new.range_last       = FIELD_W'(i_blk);
        res_new.range_item_start = i_cls.idx;
        res_new.final_result     = 1'b1;

        res_join                 = res_old;
        res_join.range_last      = FIELD_W'(i_blk);
        res_join.final_result    = 1'b1;

        res_err                  = '0;
        res_err.status           = ST_ERROR;
        res_err.final_result     = 1'b1;
    end

    always_comb begin
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_open_chunk = r_open_chunk;
        n_open_first = r_open_first;
        n_open_last  = r_open_last;
        n_open_start = r_open_start;
        o_pop        = 1'b0;

        if (r_pend_valid) begin
            // second result of a split on the last item
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end
        end else if (i_q_valid && out_free) begin
            o_pop = 1'b1;
            unique case (i_cls.kind)
                K_FIRST: begin
                    n_open_chunk = i_chunk;
                    n_open_first = i_blk;
                    n_open_last  = i_blk;
                    n_open_start = i_cls.idx;
                    if (i_cls.last) begin
                        n_out_valid = 1'b1;
                        n_out       = res_new;
                    end
                end
                K_JOIN: begin
                    n_open_last = i_blk;
                    if (i_cls.last) begin
                        n_out_valid = 1'b1;
                        n_out       = res_join;
                    end
                end
                K_SPLIT: begin
                    n_out_valid  = 1'b1;
                    n_out        = res_old;
                    n_open_chunk = i_chunk;
                    n_open_first = i_blk;
                    n_open_last  = i_blk;
                    n_open_start = i_cls.idx;
                    if (i_cls.last) begin
                        n_pend_valid = 1'b1;
                        n_pend       = res_new;
                    end
                end
                K_ERROR: begin
                    n_out_valid = 1'b1;
                    n_out       = res_err;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_pend       <= n_pend;
        r_open_chunk <= n_open_chunk;
        r_open_first <= n_open_first;
        r_open_last  <= n_open_last;
        r_open_start <= n_open_start;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_out.status;
    assign o_res.range_chunk      = r_out.range_chunk;
    assign o_res.range_first      = r_out.range_first;
    assign o_res.range_last       = r_out.range_last;
    assign o_res.range_item_start = r_out.range_item_start;
    assign o_res.final_result     = r_out.final_result;

endmodule
